>>> hw/rtl/mgfpc_pkg.sv
// ----------------------------------------------------------------------------
// mgfpc_pkg
// Shared constants, weight table and control types of the pressure filter.
// ----------------------------------------------------------------------------
package mgfpc_pkg;

  localparam int TAPS       = 12;
  localparam int CHANNELS   = 4;
  localparam int CHAN_W     = 2;
  localparam int SAMPLE_W   = 24;
  localparam int FILT_W     = 25;
  localparam int PRESS_W    = 32;
  localparam int COEF_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_OFFS   = 4;
  localparam int OFFS_IDX_W = 2;

  localparam int DEPTH      = CHANNELS * TAPS;
  localparam int WADDR_W    = $clog2(DEPTH);
  localparam int SLOT_W     = $clog2(TAPS);
  localparam int FC_W       = $clog2(TAPS + 1);

  localparam int WEIGHT_W   = 14;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = 41;
  localparam int DIFF_W     = FILT_W + 1;
  localparam int SPAN_SH    = 24;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CPROD_W    = DIFF_W + COEF_W;
  localparam int TERM_W     = CPROD_W + 1;
  localparam int LO_W       = 32;
  localparam int LPROD_W    = DIFF_W + LO_W + 1;
  localparam int HPROD_W    = DIFF_W + TERM_W - LO_W;
  localparam int P_W        = HPROD_W + LO_W + 1;
  localparam int P_SH       = 48;
  localparam int Q_W        = P_W - P_SH;

  localparam logic [CFG_IDX_W-1:0] REG_OFFS0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REF   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE = 4'd7;

  localparam logic signed [SAMPLE_W-1:0] ZERO_RST  = 24'sd3890;
  localparam logic signed [SAMPLE_W-1:0] REF_RST   = 24'sd0;
  localparam logic signed [COEF_W-1:0]   SPAN_RST  = 32'sd1950587;
  localparam logic signed [COEF_W-1:0]   CURVE_RST = -32'sd87076;

  localparam logic [WEIGHT_W-1:0] WEIGHTS [TAPS] = '{
    14'd838, 14'd1258, 14'd1808, 14'd2569, 14'd3499, 14'd4561,
    14'd5806, 14'd7064, 14'd8270, 14'd9306, 14'd10066, 14'd10485
  };

  function automatic logic [WEIGHT_W-1:0] weight(input logic [SLOT_W-1:0] idx);
    logic [WEIGHT_W-1:0] w;
    w = '0;
    if (idx < SLOT_W'(TAPS)) w = WEIGHTS[idx];
    return w;
  endfunction

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_WRITE, OP_TAP, OP_FILT, OP_CURVE,
    OP_TERM, OP_PLO, OP_PHI, OP_PADD, OP_MAG, OP_OUT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic chan_ok;
    logic out_free;
  } stat_t;

endpackage

>>> hw/rtl/mgfpc_ifs.sv
// ----------------------------------------------------------------------------
// mgfpc interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface mgfpc_in_if;
  import mgfpc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CHAN_W-1:0]          chan;
  logic signed [SAMPLE_W-1:0] sample;
  modport source(output valid, chan, sample, input ready);
  modport sink(input valid, chan, sample, output ready);
endinterface

interface mgfpc_out_if;
  import mgfpc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CHAN_W-1:0]         out_chan;
  logic signed [FILT_W-1:0]  filtered;
  logic signed [PRESS_W-1:0] pressure_pa;
  modport source(output valid, out_chan, filtered, pressure_pa, input ready);
  modport sink(input valid, out_chan, filtered, pressure_pa, output ready);
endinterface

interface mgfpc_cfg_if;
  import mgfpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, idx, data, input ready);
  modport sink(input valid, idx, data, output ready);
endinterface

>>> hw/rtl/mgfpc_ram.sv
// ----------------------------------------------------------------------------
// mgfpc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mgfpc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mgfpc_ctrl.sv
// ----------------------------------------------------------------------------
// mgfpc_ctrl
// Sequencer: window update, tap reads, calibration steps and result load.
// ----------------------------------------------------------------------------
module mgfpc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mgfpc_pkg::stat_t stat,
  output mgfpc_pkg::cmd_t  cmd
);
  import mgfpc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_WRITE  = 13'b0000000000010,
    S_TAP    = 13'b0000000000100,
    S_DRAIN1 = 13'b0000000001000,
    S_DRAIN2 = 13'b0000000010000,
    S_FILT   = 13'b0000000100000,
    S_CURVE  = 13'b0000001000000,
    S_TERM   = 13'b0000010000000,
    S_PLO    = 13'b0000100000000,
    S_PHI    = 13'b0001000000000,
    S_PADD   = 13'b0010000000000,
    S_MAG    = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] tap_r, tap_nxt;

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.tap   = tap_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && stat.chan_ok) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.op    = OP_WRITE;
        tap_nxt   = '0;
        state_nxt = S_TAP;
      end
      S_TAP: begin
        cmd.op = OP_TAP;
        if (tap_r == SLOT_W'(TAPS - 1)) begin
          state_nxt = S_DRAIN1;
        end else begin
          tap_nxt = tap_r + 1'b1;
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_FILT;
      S_FILT: begin
        cmd.op    = OP_FILT;
        state_nxt = S_CURVE;
      end
      S_CURVE: begin
        cmd.op    = OP_CURVE;
        state_nxt = S_TERM;
      end
      S_TERM: begin
        cmd.op    = OP_TERM;
        state_nxt = S_PLO;
      end
      S_PLO: begin
        cmd.op    = OP_PLO;
        state_nxt = S_PHI;
      end
      S_PHI: begin
        cmd.op    = OP_PHI;
        state_nxt = S_PADD;
      end
      S_PADD: begin
        cmd.op    = OP_PADD;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

endmodule

>>> hw/rtl/mgfpc_dp.sv
// ----------------------------------------------------------------------------
// mgfpc_dp
// Window store, shared multiplier, accumulator, calibration and result reg.
// ----------------------------------------------------------------------------
module mgfpc_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mgfpc_pkg::cmd_t                       cmd,
  output mgfpc_pkg::stat_t                      stat,
  input  logic [mgfpc_pkg::CHAN_W-1:0]          in_chan,
  input  logic signed [mgfpc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                  cfg_valid,
  input  logic [mgfpc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [mgfpc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mgfpc_pkg::CHAN_W-1:0]          out_chan,
  output logic signed [mgfpc_pkg::FILT_W-1:0]   filtered,
  output logic signed [mgfpc_pkg::PRESS_W-1:0]  pressure_pa
);
  import mgfpc_pkg::*;

  // configuration
  logic signed [SAMPLE_W-1:0] offs_r [NUM_OFFS];
  logic signed [SAMPLE_W-1:0] zero_r, ref_r;
  logic signed [COEF_W-1:0]   span_r, curve_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_OFFS; i++) offs_r[i] <= '0;
      zero_r  <= ZERO_RST;
      ref_r   <= REF_RST;
      span_r  <= SPAN_RST;
      curve_r <= CURVE_RST;
    end else if (cfg_valid) begin
      case (cfg_idx)
        REG_OFFS0, REG_OFFS1, REG_OFFS2, REG_OFFS3:
          offs_r[cfg_idx[OFFS_IDX_W-1:0]] <= cfg_data[SAMPLE_W-1:0];
        REG_ZERO:  zero_r  <= cfg_data[SAMPLE_W-1:0];
        REG_REF:   ref_r   <= cfg_data[SAMPLE_W-1:0];
        REG_SPAN:  span_r  <= cfg_data[COEF_W-1:0];
        REG_CURVE: curve_r <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // fill state per lane
  logic [FC_W-1:0]   fc_r [CHANNELS];
  logic [SLOT_W-1:0] wp_r [CHANNELS];
  logic [SLOT_W-1:0] wp_step;

  logic [CHAN_W-1:0]          chan_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [FC_W-1:0]            fc_cur_r;
  logic [SLOT_W-1:0]          wp_new_r;

  assign wp_step = (wp_r[chan_r] == SLOT_W'(TAPS - 1)) ? '0 : wp_r[chan_r] + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fc_r[i] <= '0;
        wp_r[i] <= '0;
      end
    end else if (cmd.op == OP_WRITE) begin
      wp_r[chan_r] <= wp_step;
      if (fc_r[chan_r] < FC_W'(TAPS)) fc_r[chan_r] <= fc_r[chan_r] + 1'b1;
    end
  end

  // window store
  logic [WADDR_W-1:0]  base;
  logic [SLOT_W-1:0]   rd_slot;
  logic [SLOT_W:0]     rd_sum;
  logic [WADDR_W-1:0]  rd_addr;
  logic [WADDR_W-1:0]  wr_addr;
  logic [SAMPLE_W-1:0] rd_data;

  assign base    = WADDR_W'(chan_r) * WADDR_W'(TAPS);
  assign rd_sum  = {1'b0, wp_new_r} + {1'b0, cmd.tap};
  assign wr_addr = base + WADDR_W'(wp_r[chan_r]);
  assign rd_addr = base + WADDR_W'(rd_slot);

  always_comb begin
    if (fc_cur_r < FC_W'(TAPS)) begin
      rd_slot = (FC_W'(cmd.tap) < fc_cur_r) ? cmd.tap : SLOT_W'(fc_cur_r);
    end else if (rd_sum >= (SLOT_W + 1)'(TAPS)) begin
      rd_slot = SLOT_W'(rd_sum - (SLOT_W + 1)'(TAPS));
    end else begin
      rd_slot = SLOT_W'(rd_sum);
    end
  end

  mgfpc_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_win (
    .clk   (clk),
    .we    (cmd.op == OP_WRITE),
    .waddr (wr_addr),
    .wdata (sample_r),
    .re    (cmd.op == OP_TAP),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // tap pipeline valids
  logic              mac_v1_r, mac_v2_r;
  logic [SLOT_W-1:0] tap_d1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_v1_r <= 1'b0;
      mac_v2_r <= 1'b0;
    end else begin
      mac_v1_r <= (cmd.op == OP_TAP);
      mac_v2_r <= mac_v1_r;
    end
  end

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [FILT_W-1:0] filt_r;
  logic signed [DIFF_W-1:0] d0, d1;
  logic signed [TERM_W-1:0] term_r;

  assign d0 = DIFF_W'(filt_r) - DIFF_W'(zero_r);
  assign d1 = DIFF_W'(filt_r) - DIFF_W'(ref_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (mac_v1_r) begin
      mul_a = MUL_W'(signed'(rd_data));
      mul_b = MUL_W'(weight(tap_d1_r));
    end else begin
      case (cmd.op)
        OP_CURVE: begin
          mul_a = MUL_W'(d1);
          mul_b = MUL_W'(curve_r);
        end
        OP_PLO: begin
          mul_a = MUL_W'(d0);
          mul_b = MUL_W'(term_r[LO_W-1:0]);
        end
        OP_PHI: begin
          mul_a = MUL_W'(d0);
          mul_b = MUL_W'(signed'(term_r[TERM_W-1:LO_W]));
        end
        default: ;
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // arithmetic registers
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_adj;
  logic signed [ACC_W-1:0]   acc_sh;
  logic signed [P_W-1:0]     p_r;
  logic [P_W-1:0]            p_mag;
  logic [Q_W-1:0]            q_r;
  logic                      neg_r;
  logic signed [PRESS_W-1:0] press;

  assign acc_adj = acc_r + (acc_r[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : '0);
  assign acc_sh  = acc_adj >>> FRAC_W;
  assign p_mag   = p_r[P_W-1] ? -p_r : p_r;

  always_comb begin
    if (neg_r) begin
      if (q_r > Q_W'(64'd1 << (PRESS_W - 1))) press = {1'b1, {(PRESS_W-1){1'b0}}};
      else press = -signed'(q_r[PRESS_W-1:0]);
    end else begin
      if (q_r > Q_W'((64'd1 << (PRESS_W - 1)) - 64'd1)) press = {1'b0, {(PRESS_W-1){1'b1}}};
      else press = signed'(q_r[PRESS_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (cmd.op == OP_LOAD) begin
      chan_r   <= in_chan;
      sample_r <= in_sample;
    end
    if (cmd.op == OP_WRITE) begin
      fc_cur_r <= fc_r[chan_r];
      wp_new_r <= wp_step;
      acc_r    <= '0;
    end else if (mac_v2_r) begin
      acc_r <= acc_r + signed'(prod_r[ACC_W-1:0]);
    end
    tap_d1_r <= cmd.tap;
    case (cmd.op)
      OP_FILT: filt_r <= signed'(acc_sh[FILT_W-1:0]) - FILT_W'(offs_r[chan_r]);
      OP_TERM: term_r <= (TERM_W'(span_r) <<< SPAN_SH) + TERM_W'(signed'(prod_r[CPROD_W-1:0]));
      OP_PHI:  p_r <= P_W'(signed'(prod_r[LPROD_W-1:0]));
      OP_PADD: p_r <= p_r + (P_W'(signed'(prod_r[HPROD_W-1:0])) <<< LO_W);
      OP_MAG: begin
        neg_r <= p_r[P_W-1];
        q_r   <= p_mag[P_W-1:P_SH];
      end
      default: ;
    endcase
  end

  // result register
  logic                      out_valid_r;
  logic [CHAN_W-1:0]         out_chan_r;
  logic signed [FILT_W-1:0]  out_filt_r;
  logic signed [PRESS_W-1:0] out_press_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_chan_r  <= chan_r;
      out_filt_r  <= filt_r;
      out_press_r <= press;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_chan      = out_chan_r;
  assign filtered      = out_filt_r;
  assign pressure_pa   = out_press_r;
  assign stat.chan_ok  = 32'(in_chan) < CHANNELS;
  assign stat.out_free = !out_valid_r || out_ready;

`ifndef SYNTH
  a_fill_wp: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_WRITE && fc_r[chan_r] < FC_W'(TAPS)) |->
      wp_r[chan_r] == SLOT_W'(fc_r[chan_r]))
    else $error("write slot out of step with fill count");
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_WRITE |-> fc_r[chan_r] <= FC_W'(TAPS))
    else $error("fill count beyond tap count");
  a_mac_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FILT |-> !mac_v1_r && !mac_v2_r)
    else $error("accumulator read before last tap");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT |-> !out_valid_r || out_ready)
    else $error("result word overwritten");
`endif

endmodule

>>> hw/rtl/multichannel_gaussian_fir_pressure_cal_top.sv
// ----------------------------------------------------------------------------
// multichannel_gaussian_fir_pressure_cal_top
// Four-lane 12-tap weighted smoothing filter with offset and pressure cal.
// ----------------------------------------------------------------------------
// each input word goes from acceptance to its result being loaded in the
// output register through the window write, one read per tap from the single
// window memory read port, and the shared multiplier used for the taps and
// three calibration products; a new word is accepted the cycle after the
// result is loaded, while that result still waits for out ready
module multichannel_gaussian_fir_pressure_cal_top (
  input logic         clk,
  input logic         rst_n,
  mgfpc_in_if.sink    in_if,
  mgfpc_out_if.source out_if,
  mgfpc_cfg_if.sink   cfg_if
);
  import mgfpc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_if.ready = 1'b1;

  mgfpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mgfpc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_chan     (in_if.chan),
    .in_sample   (in_if.sample),
    .cfg_valid   (cfg_if.valid),
    .cfg_idx     (cfg_if.idx),
    .cfg_data    (cfg_if.data),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_chan    (out_if.out_chan),
    .filtered    (out_if.filtered),
    .pressure_pa (out_if.pressure_pa)
  );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-lane 12-tap pressure filter. It drives
// sample words and register writes under several idle and stall patterns.
// It predicts each result from its own copy of the windows, the fill
// counters and the calibration, and compares every output field in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mgfpc_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [CHAN_W-1:0]          ch;
    logic signed [FILT_W-1:0]   filt;
    logic signed [PRESS_W-1:0]  pa;
  } press_result_t;

  logic clk;
  logic rst_n;

  mgfpc_in_if  in_if();
  mgfpc_out_if out_if();
  mgfpc_cfg_if cfg_if();

  multichannel_gaussian_fir_pressure_cal_top uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  const longint tap_wt [TAPS] = '{838, 1258, 1808, 2569, 3499, 4561,
                                 5806, 7064, 8270, 9306, 10066, 10485};

  logic signed [SAMPLE_W-1:0] hist [CHANNELS][TAPS];
  int unsigned                fill [CHANNELS];
  logic signed [SAMPLE_W-1:0] lane_offs [NUM_OFFS];
  logic signed [SAMPLE_W-1:0] zero_cnt;
  logic signed [SAMPLE_W-1:0] ref_cnt;
  logic signed [COEF_W-1:0]   span;
  logic signed [COEF_W-1:0]   curve;

  press_result_t pending_results[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic press_result_t filter_and_calibrate(logic [CHAN_W-1:0] c,
                                                          logic signed [SAMPLE_W-1:0] s);
    press_result_t r;
    longint acc, filt, d1, trm;
    logic signed [127:0] prod, mag, q;
    bit neg;
    acc = 0;
    if (fill[c] < TAPS) begin
      for (int i = fill[c]; i < TAPS; i++) hist[c][i] = s;
      fill[c]++;
    end else begin
      for (int i = 0; i < TAPS - 1; i++) hist[c][i] = hist[c][i+1];
      hist[c][TAPS-1] = s;
    end
    for (int i = 0; i < TAPS; i++) acc += tap_wt[i] * longint'(hist[c][i]);
    filt = acc / 65536 - longint'(lane_offs[c]);
    d1 = filt - longint'(ref_cnt);
    trm = longint'(span) * 64'sd16777216 + d1 * longint'(curve);
    prod = 128'(filt - longint'(zero_cnt)) * 128'(trm);
    neg = prod < 0;
    mag = neg ? -prod : prod;
    q = mag >>> P_SH;
    r.ch = c;
    r.filt = filt[FILT_W-1:0];
    if (neg) r.pa = (q > 128'sd2147483648) ? 32'sh80000000 : 32'(-q);
    else r.pa = (q > 128'sd2147483647) ? 32'sh7fffffff : 32'(q);
    return r;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_OFFS0, REG_OFFS1, REG_OFFS2, REG_OFFS3: lane_offs[idx[OFFS_IDX_W-1:0]] = data[23:0];
      REG_ZERO:  zero_cnt = data[23:0];
      REG_REF:   ref_cnt = data[23:0];
      REG_SPAN:  span = data;
      REG_CURVE: curve = data;
      default: ;
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_word(logic [CHAN_W-1:0] c, logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.chan = c;
    in_if.sample = s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(filter_and_calibrate(c, s));
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.idx = idx;
    cfg_if.data = data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(3))
      0: return SAMPLE_W'($urandom);
      1: return zero_cnt + SAMPLE_W'($signed(32'($urandom_range(4000)) - 2000));
      2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      default: return SAMPLE_W'($signed(32'($urandom_range(2000)) - 1000));
    endcase
  endfunction

  task automatic test_reset_defaults();
    for (int c = 0; c < CHANNELS; c++) send_word(CHAN_W'(c), 24'sd3890 + SAMPLE_W'(c));
    for (int i = 0; i < 8; i++) send_word(2'd0, 24'sd4000 + SAMPLE_W'(i * 50));
  endtask

  task automatic test_extremes();
    wait_idle();
    write_register(REG_OFFS0, 32'h007fffff);
    write_register(REG_OFFS1, 32'hff800000);
    write_register(REG_OFFS2, 32'h0);
    write_register(REG_OFFS3, 32'hffffffff);
    write_register(REG_ZERO, 32'h00800000);
    write_register(REG_REF, 32'h007fffff);
    write_register(REG_SPAN, 32'h7fffffff);
    write_register(REG_CURVE, 32'h80000000);
    write_register(4'd9, 32'h12345678);
    write_register(4'd15, 32'hffffffff);
    send_word(2'd0, 24'sh800000);
    send_word(2'd1, 24'sh7fffff);
    send_word(2'd2, 24'sh7fffff);
    send_word(2'd3, 24'sh800000);
    send_word(2'd2, 24'sh800000);
    wait_idle();
    write_register(REG_SPAN, 32'h80000000);
    write_register(REG_CURVE, 32'h7fffffff);
    write_register(REG_ZERO, 32'h007fffff);
    write_register(REG_REF, 32'h00800000);
    send_word(2'd1, 24'sh800000);
    send_word(2'd3, 24'sh7fffff);
    send_word(2'd0, 24'sd0);
    wait_idle();
    write_register(REG_SPAN, 32'h0);
    write_register(REG_CURVE, 32'h0);
    send_word(2'd2, 24'sd1);
  endtask

  task automatic test_random(int idle, int stall, int n);
    wait_idle();
    idle_pct = idle;
    stall_pct = stall;
    for (int k = 0; k < 2; k++) begin
      wait_idle();
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(1)) write_register(CFG_IDX_W'(r), $urandom);
      end
      if ($urandom_range(1)) begin
        write_register(REG_SPAN, 32'($urandom_range(4000000)));
        write_register(REG_CURVE, -32'($urandom_range(200000)));
      end
      for (int i = 0; i < n / 2; i++) begin
        send_word(CHAN_W'($urandom_range(CHANNELS - 1)), pick_sample());
        if (i == n / 4 && k == 0) begin
          in_if.valid = 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
      end
    end
  endtask

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    press_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result word on lane %0d at %0t", out_if.out_chan, $realtime);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.out_chan !== want.ch) report_mismatch("out_chan", out_if.out_chan, want.ch);
        if (out_if.filtered !== want.filt) report_mismatch("filtered", out_if.filtered, want.filt);
        if (out_if.pressure_pa !== want.pa)
          report_mismatch("pressure_pa", out_if.pressure_pa, want.pa);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.chan = '0;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.idx = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      fill[c] = 0;
      for (int i = 0; i < TAPS; i++) hist[c][i] = '0;
    end
    for (int c = 0; c < NUM_OFFS; c++) lane_offs[c] = '0;
    zero_cnt = ZERO_RST;
    ref_cnt = REF_RST;
    span = SPAN_RST;
    curve = CURVE_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_extremes();
    test_random(0, 0, 160);
    test_random(75, 0, 150);
    test_random(0, 75, 150);
    test_random(36, 36, 160);
    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/mgfpc_pkg.sv
hw/rtl/mgfpc_ifs.sv
hw/rtl/mgfpc_ram.sv
hw/rtl/mgfpc_ctrl.sv
hw/rtl/mgfpc_dp.sv
hw/rtl/multichannel_gaussian_fir_pressure_cal_top.sv
sim/testbench.sv
